### sv/sha256_message_digest_core_assert.svh
// Assertion macros shared by the SHA-256 digest core modules.
// Depends on nothing; included inside module bodies.
`ifndef SHA256_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/sha_pkg.sv
// Package for the SHA-256 digest core: types, constants and round functions.
// Depends on nothing; imported by every module of the core.
`default_nettype none

package sha_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One byte transaction passed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_byte_item;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

`default_nettype wire

### sv/sha_front.sv
// Front part of the SHA-256 core: accepts input transactions into a short queue.
// Depends on sha_pkg.
`default_nettype none

module sha_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire sha_pkg::t_byte_item i_item,
    output logic                     o_full,
    output logic                     o_valid,
    output sha_pkg::t_byte_item      o_item,
    input  wire logic                i_take
);
    import sha_pkg::*;

    t_byte_item            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_AW:0]     r_count;
    logic                  w_put;
    logic                  w_get;

    // Idle items carry no work and are dropped here.
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_put   = i_push && !o_full && (i_item.present || i_item.last);
    assign o_valid = (r_count != '0);
    assign w_get   = o_valid && i_take;
    assign o_item  = r_mem[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_put) r_wr <= r_wr + 1'b1;
            if (w_get) r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QUEUE_AW+1)'(w_put) - (QUEUE_AW+1)'(w_get);
        end
    end

    `include "sha256_message_digest_core_assert.svh"
    `SHA_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, 1'b1, r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    `SHA_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_put && !w_get, r_count == $past(r_count) + 1'b1)
    `SHA_ASSERT_NEXT(a_count_dn, i_clk, i_rst_n, w_get && !w_put, r_count == $past(r_count) - 1'b1)

endmodule

`default_nettype wire

### sv/sha_back.sv
// Back part of the SHA-256 core: block packing, padding, compression, output.
// Depends on sha_pkg.
`default_nettype none

module sha_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire sha_pkg::t_byte_item i_item,
    output logic                     o_take,
    output logic [31:0]              o_digest_word,
    output logic [2:0]               o_word_index,
    output logic                     o_last_word,
    output logic                     o_empty,
    input  wire logic                i_pop
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_FILL, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_hash [8];
    logic [31:0]  r_var  [8];
    logic [31:0]  r_win  [16];
    logic [5:0]   r_pos;
    logic [63:0]  r_len;
    logic [5:0]   r_round;
    logic         r_final;
    logic [2:0]   r_oidx;
    logic         r_mark_done;
    logic         r_pad_done;
    logic         r_extra;
    logic [7:0]   w_byte;
    logic [7:0]   w_len_byte;
    logic [31:0]  w_wt;
    logic [31:0]  w_t1;
    logic [31:0]  w_t2;
    logic [31:0]  w_ch;
    logic [31:0]  w_maj;
    logic [3:0]   w_slot;

    assign o_take        = (r_state == ST_FILL) && i_valid;
    assign o_empty       = (r_state != ST_OUT);
    assign o_digest_word = r_hash[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    // Padding byte: 0x80 at the message end, then zeros, then the length.
    // A block whose marker sits past byte 55 has no room for the length.
    always_comb begin
        w_len_byte = r_len[8'(63 - 8 * int'(r_pos[2:0])) -: 8];
        if (!r_mark_done)                    w_byte = 8'h80;
        else if (r_pos >= 6'd56 && !r_extra) w_byte = w_len_byte;
        else                                 w_byte = 8'h00;
    end

    // Schedule word and round datapath.
    always_comb begin
        w_slot = r_round[3:0];
        if (r_round < 6'd16) begin
            w_wt = r_win[w_slot];
        end else begin
            w_wt = r_win[w_slot] + small_sigma0(r_win[w_slot + 4'd1])
                 + r_win[w_slot + 4'd9] + small_sigma1(r_win[w_slot + 4'd14]);
        end
        w_ch  = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        w_maj = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        w_t1  = r_var[7] + big_sigma1(r_var[4]) + w_ch + ROUND_K[r_round] + w_wt;
        w_t2  = big_sigma0(r_var[0]) + w_maj;
    end

    // Sequencer: bytes shift into the schedule window, which doubles as buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_pos   <= '0;
            r_len   <= '0;
            r_round <= '0;
            r_final <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) r_hash[i] <= INIT_HASH[i];
        end else begin
            case (r_state)
                ST_FILL: begin
                    if (o_take) begin
                        if (i_item.present) begin
                            r_win[r_pos[5:2]][8'(31 - 8 * int'(r_pos[1:0])) -: 8]
                                <= i_item.data;
                            r_pos <= r_pos + 6'd1;
                            r_len <= r_len + 64'd8;
                        end
                        r_final <= i_item.last;
                        if (i_item.present && r_pos == 6'd63) begin
                            r_state <= ST_LOAD;
                        end else if (i_item.last) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // The 0x80 marker goes in first, then zeros and the length.
                    r_win[r_pos[5:2]][8'(31 - 8 * int'(r_pos[1:0])) -: 8] <= w_byte;
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    for (int i = 0; i < 8; i++) r_var[i] <= r_hash[i];
                    r_round <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_win[w_slot] <= w_wt;
                    r_var[7] <= r_var[6];
                    r_var[6] <= r_var[5];
                    r_var[5] <= r_var[4];
                    r_var[4] <= r_var[3] + w_t1;
                    r_var[3] <= r_var[2];
                    r_var[2] <= r_var[1];
                    r_var[1] <= r_var[0];
                    r_var[0] <= w_t1 + w_t2;
                    r_round  <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_var[i];
                    r_pos <= '0;
                    if (!r_final) begin
                        r_state <= ST_FILL;
                    end else if (r_pad_done) begin
                        r_oidx  <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_PAD;
                    end
                end
                ST_OUT: begin
                    if (i_pop) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_hash[i] <= INIT_HASH[i];
                            r_len   <= '0;
                            r_final <= 1'b0;
                            r_state <= ST_FILL;
                        end
                    end
                end
                default: r_state <= ST_FILL;
            endcase
        end
    end

    // Padding progress: the 0x80 marker, a marker block with no room for the
    // length, and whether the length is in place.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_done <= 1'b0;
            r_pad_done  <= 1'b0;
            r_extra     <= 1'b0;
        end else begin
            if (r_state == ST_PAD) begin
                if (!r_mark_done) r_mark_done <= 1'b1;
                if (r_pos == 6'd63) begin
                    r_extra <= 1'b0;
                    if (r_mark_done && !r_extra) r_pad_done <= 1'b1;
                end else if (!r_mark_done && r_pos >= 6'd56) begin
                    r_extra <= 1'b1;
                end
            end
            if (r_state == ST_OUT && i_pop && r_oidx == 3'd7) begin
                r_mark_done <= 1'b0;
                r_pad_done  <= 1'b0;
            end
        end
    end

    `include "sha256_message_digest_core_assert.svh"
    `SHA_ASSERT_IMP(a_out_final, i_clk, i_rst_n, r_state == ST_OUT, r_final && r_pad_done)
    `SHA_ASSERT_NEXT(a_round_step, i_clk, i_rst_n, r_state == ST_ROUND && r_round != 6'd63, r_round == $past(r_round) + 6'd1)
    `SHA_ASSERT_IMP(a_take_fill, i_clk, i_rst_n, o_take, r_state == ST_FILL)

endmodule

`default_nettype wire

### sv/sha256_message_digest_core.sv
// SHA-256 digest core, one message byte per input transaction:
// byte_present marks a real byte, end_of_message closes the message.
// Eight digest word transactions follow each message, h0 first, last_word
// high on h7, through a queue-style result port (empty/pop).
// Flow: bytes enter a 4-entry queue and are packed one per cycle while the
// back part is filling; each 64-byte block then passes through the back part
// (load, 64 rounds of one shared round unit, add) before it takes more bytes.
// End of message adds padding and one or two compressions,
// then eight words, each held until popped.
// While the receiver stalls the back part holds, the queue fills and full
// rises. Idle transactions are dropped at the queue.
// Reset: synchronous, active low; restores the initial hash values, clears
// the length, the block position and the queue; no clearing pass.
// Depends on sha_pkg, sha_front, sha_back.
`default_nettype none

module sha256_message_digest_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_message_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    import sha_pkg::*;

    t_byte_item w_in;
    t_byte_item w_q;
    logic       w_valid;
    logic       w_take;

    assign w_in = '{data: i_message_byte, present: i_byte_present, last: i_end_of_message};

    sha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (w_in),
        .o_full  (full),
        .o_valid (w_valid),
        .o_item  (w_q),
        .i_take  (w_take)
    );

    sha_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid),
        .i_item        (w_q),
        .o_take        (w_take),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .o_empty       (empty),
        .i_pop         (pop)
    );

endmodule

`default_nettype wire
